FILE: src/skic_pkg.sv
// Shared types and constants for the sorted key index cursor.
// No dependencies; imported by the engine and the top level.
`default_nettype none

package skic_pkg;

   localparam int OP_W  = 3;
   localparam int KEY_W = 64;
   localparam int POS_W = 32;
   localparam int KB_W  = 4;

   localparam logic [POS_W-1:0] MISS_CODE = '1;

   localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
   localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
   localparam logic [OP_W-1:0] OP_PREV   = 3'd4;
   localparam logic [OP_W-1:0] OP_TOP    = 3'd5;
   localparam logic [OP_W-1:0] OP_BOTTOM = 3'd6;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd7;

   localparam logic [KB_W-1:0] KEY_BYTES_RESET = 4'd8;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] position;
      logic             overflow;
   } res_type;

   // Mask over the leading n bytes of a key; n already saturated to 0..8.
   function automatic logic [KEY_W-1:0] key_mask(input logic [KB_W-1:0] n);
      logic [6:0] shamt;
      begin
         shamt = 7'd64 - {n[3:0], 3'b000};
         if (n == '0) begin
            key_mask = '0;
         end else begin
            key_mask = {KEY_W{1'b1}} << shamt;
         end
      end
   endfunction

endpackage

`default_nettype wire

FILE: src/skic_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module skic_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: src/skic_engine.sv
// Command sequencer: table RAM, entry count, cursor and binary-search loop.
// Depends on skic_pkg and skic_ram.
`default_nettype none

module skic_engine #(
   parameter int TABLE_DEPTH   = 1024,
   parameter int KEY_MAX_BYTES = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [skic_pkg::OP_W-1:0]     op,
   input  wire logic [skic_pkg::KEY_W-1:0]    key,
   input  wire logic [skic_pkg::POS_W-1:0]    record_pos,
   input  wire logic [skic_pkg::KB_W-1:0]     key_bytes,
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output skic_pkg::res_type                  res
);
   import skic_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int RW = KEY_W + POS_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [KB_W-1:0] KB_MAX = KB_W'(KEY_MAX_BYTES);

   typedef enum logic [2:0] {
      S_IDLE, S_LOOK, S_CMP, S_CUR, S_CUR_WAIT, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     cursor_ff, cursor_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;      // exclusive upper bound
   logic [CW-1:0]     mid_ff, mid_in;
   logic              nearest_ff, nearest_in;
   logic [KEY_W-1:0]  mask_ff, mask_in;
   logic [KEY_W-1:0]  want_ff, want_in;
   res_type           res_ff, res_in;

   logic              wr_en;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [RW-1:0]     rd_data;
   logic [KEY_W-1:0]  rd_key;
   logic [POS_W-1:0]  rd_pos;

   logic [KB_W-1:0]   kb_sat;
   logic [KEY_W-1:0]  have;
   logic              key_eq;
   logic              key_gt;
   logic [CW-1:0]     mid_inc;
   logic [CW-1:0]     probe_lo;
   logic [CW-1:0]     probe_hi;
   logic              probe_go;
   logic [CW:0]       probe_sum;
   logic [CW-1:0]     probe_mid;
   res_type           res_miss;

   skic_ram #(
      .WIDTH (RW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({record_pos, key}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key = rd_data[KEY_W-1:0];
   assign rd_pos = rd_data[RW-1:KEY_W];

   assign kb_sat  = (key_bytes > KB_MAX) ? KB_MAX : key_bytes;
   assign have    = rd_key & mask_ff;
   assign key_eq  = (have == want_ff);
   assign key_gt  = (want_ff > have);
   assign mid_inc = mid_ff + CW'(1);

   // Range for the next probe: the start range, or the one narrowed by this compare.
   always_comb begin
      if (state_ff == S_CMP) begin
         probe_lo = key_gt ? mid_inc : lo_ff;
         probe_hi = key_gt ? hi_ff : mid_ff;
      end else begin
         probe_lo = lo_ff;
         probe_hi = hi_ff;
      end
   end

   assign probe_go  = (probe_lo < probe_hi);
   assign probe_sum = {1'b0, probe_lo} + {1'b0, probe_hi} - (CW+1)'(1);
   assign probe_mid = probe_sum[CW:1];

   assign res_miss = '{hit: 1'b0, position: MISS_CODE, overflow: 1'b0};

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      nearest_in = nearest_ff;
      mask_in    = mask_ff;
      want_in    = want_ff;
      res_in     = res_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      req_ready  = (state_ff == S_IDLE);
      res_valid  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in   = '0;
               state_in = S_DONE;
               case (op)
                  OP_LOAD: begin
                     if (count_ff < DEPTH_C) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        res_in.overflow = 1'b1;
                     end
                  end
                  OP_FIND, OP_SEARCH: begin
                     lo_in      = '0;
                     hi_in      = count_ff;
                     nearest_in = (op == OP_SEARCH);
                     mask_in    = key_mask(kb_sat);
                     want_in    = key & key_mask(kb_sat);
                     state_in   = S_LOOK;
                  end
                  OP_NEXT: begin
                     state_in = S_CUR;
                  end
                  OP_PREV: begin
                     if (cursor_ff >= CW'(2)) begin
                        cursor_in = cursor_ff - CW'(2);
                        state_in  = S_CUR;
                     end else begin
                        res_in = res_miss;
                     end
                  end
                  OP_TOP: begin
                     cursor_in = '0;
                     state_in  = S_CUR;
                  end
                  OP_BOTTOM: begin
                     if (count_ff != '0) begin
                        cursor_in = count_ff - CW'(1);
                        state_in  = S_CUR;
                     end else begin
                        res_in = res_miss;
                     end
                  end
                  default: begin
                     count_in  = '0;
                     cursor_in = '0;
                  end
               endcase
            end
         end

         S_LOOK: begin
            if (probe_go) begin
               rd_en    = 1'b1;
               rd_addr  = probe_mid[AW-1:0];
               mid_in   = probe_mid;
               state_in = S_CMP;
            end else begin
               res_in   = res_miss;
               state_in = S_DONE;
            end
         end

         // Compare the probed key and issue the next probe in the same cycle.
         S_CMP: begin
            cursor_in = mid_inc;
            if (key_eq) begin
               res_in   = '{hit: 1'b1, position: rd_pos, overflow: 1'b0};
               state_in = S_DONE;
            end else begin
               lo_in = probe_lo;
               hi_in = probe_hi;
               if (probe_go) begin
                  rd_en   = 1'b1;
                  rd_addr = probe_mid[AW-1:0];
                  mid_in  = probe_mid;
               end else begin
                  res_in.hit      = 1'b0;
                  res_in.position = nearest_ff ? rd_pos : MISS_CODE;
                  res_in.overflow = 1'b0;
                  state_in        = S_DONE;
               end
            end
         end

         S_CUR: begin
            if (cursor_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = cursor_ff[AW-1:0];
               state_in = S_CUR_WAIT;
            end else begin
               res_in   = res_miss;
               state_in = S_DONE;
            end
         end

         S_CUR_WAIT: begin
            res_in    = '{hit: 1'b1, position: rd_pos, overflow: 1'b0};
            cursor_in = cursor_ff + CW'(1);
            state_in  = S_DONE;
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      nearest_ff <= nearest_in;
      mask_ff    <= mask_in;
      want_ff    <= want_in;
      res_ff     <= res_in;
   end

   assign res = res_ff;

`ifndef SYNTH
   a_cursor_in_table : assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff)
      else $error("cursor beyond entry count");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count beyond table depth");

   a_probe_in_range : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> (mid_ff >= lo_ff) && (mid_ff < hi_ff) && (hi_ff <= count_ff))
      else $error("probe index outside search range");

   a_full_refuses : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && res_ff.overflow |-> count_ff == DEPTH_C)
      else $error("overflow reported with room in table");
`endif

endmodule

`default_nettype wire

FILE: src/sorted_key_index_cursor.sv
// Channel   Dir  Payload (tdata / tuser)                    Transfer
// req_      in   tdata: key, record_pos ; tuser: op         req_tvalid & req_tready
// rsp_      out  tdata: position ; tuser: hit, overflow      rsp_tvalid & rsp_tready
// csr_      in   csr_data: key_bytes                         csr_valid & csr_ready
//
// One command at a time. Find/search make up to ceil(log2(entry_count+1)) probes of the
// table RAM, each compare issuing the next probe, the RAM read latency setting the loop;
// a cursor read makes one RAM read, and load, clear and refused moves make none.
// Synchronous reset empties the table, homes the cursor and sets key_bytes to 8.
// A finished result sits in the output register, so the next request is taken while
// the response side stalls. Depends on skic_pkg, skic_engine, skic_ram.
`default_nettype none

module sorted_key_index_cursor #(
   parameter int TABLE_DEPTH   = 1024,
   parameter int KEY_MAX_BYTES = 8
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          req_tvalid,
   output logic                                               req_tready,
   input  wire logic [skic_pkg::KEY_W+skic_pkg::POS_W-1:0]    req_tdata,  // key, record_pos
   input  wire logic [skic_pkg::OP_W-1:0]                     req_tuser,  // op
   output logic                                               rsp_tvalid,
   input  wire logic                                          rsp_tready,
   output logic      [skic_pkg::POS_W-1:0]                    rsp_tdata,  // position
   output logic      [1:0]                                    rsp_tuser,  // hit, overflow
   input  wire logic                                          csr_valid,
   output logic                                               csr_ready,
   input  wire logic [skic_pkg::KB_W-1:0]                     csr_data    // key_bytes
);
   import skic_pkg::*;

   logic [KB_W-1:0] key_bytes_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   res_type         rsp_res_ff, rsp_res_in;
   logic            res_valid;
   logic            res_ready;
   res_type         res;

   skic_engine #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .KEY_MAX_BYTES (KEY_MAX_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .op         (req_tuser),
      .key        (req_tdata[KEY_W-1:0]),
      .record_pos (req_tdata[KEY_W+POS_W-1:KEY_W]),
      .key_bytes  (key_bytes_ff),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   assign csr_ready = 1'b1;

   // Output register frees up as soon as the current response is taken.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff <= KEY_BYTES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            key_bytes_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_res_ff.position;
   assign rsp_tuser  = {rsp_res_ff.overflow, rsp_res_ff.hit};

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking bench for sorted_key_index_cursor: directed table then random traffic,
// every result held to its typed value or a behavioural table/cursor predictor.
// Depends on skic_pkg and the RTL under src/.

module testbench;
   import skic_pkg::*;

   localparam int DEPTH = 1024;
   localparam res_type MISS_RES = {1'b0, MISS_CODE, 1'b0};
   localparam res_type ZERO_RES = '0;

   typedef struct packed {
      logic             typed;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [POS_W-1:0] rpos;
      res_type          want;
   } stim_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [KEY_W+POS_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]        req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [POS_W-1:0]       rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [KB_W-1:0]        csr_data   = '0;

   // predictor state
   logic [KEY_W-1:0] tab_key [0:DEPTH-1];
   logic [POS_W-1:0] tab_pos [0:DEPTH-1];
   int               tab_count = 0;
   int               cur = 0;
   logic [KB_W-1:0]  cmp_bytes = KEY_BYTES_RESET;

   res_type      pending [$];
   stim_row_type plan [$];
   int           mismatch_count = 0;
   int unsigned  tx_gap_pct = 6;
   int unsigned  rx_idle_pct = 60;

   sorted_key_index_cursor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [KEY_W-1:0] prefix_mask(input logic [KB_W-1:0] nb);
      int n;
      n = (nb > 8) ? 8 : int'(nb);
      if (n == 0) return '0;
      return {KEY_W{1'b1}} << (64 - 8 * n);
   endfunction

   function automatic res_type cursor_read();
      res_type r;
      r = MISS_RES;
      if (cur < tab_count) begin
         r.hit = 1'b1;
         r.position = tab_pos[cur];
         cur++;
      end
      return r;
   endfunction

   function automatic res_type predict_result(input logic [OP_W-1:0] op,
                                              input logic [KEY_W-1:0] key,
                                              input logic [POS_W-1:0] rpos);
      res_type          r;
      logic [KEY_W-1:0] m, want_k, have;
      int               lo, hi, mid;
      r = ZERO_RES;
      case (op)
         OP_LOAD: begin
            if (tab_count < DEPTH) begin
               tab_key[tab_count] = key;
               tab_pos[tab_count] = rpos;
               tab_count++;
            end else begin
               r.overflow = 1'b1;
            end
         end
         OP_FIND, OP_SEARCH: begin
            m = prefix_mask(cmp_bytes);
            want_k = key & m;
            lo = 0;
            hi = tab_count - 1;
            mid = -1;
            r.position = MISS_CODE;
            while (lo <= hi) begin
               mid = (lo + hi) / 2;
               have = tab_key[mid] & m;
               cur = mid + 1;
               if (have == want_k) begin
                  r.hit = 1'b1;
                  r.position = tab_pos[mid];
                  break;
               end
               if (want_k > have) lo = mid + 1;
               else hi = mid - 1;
            end
            // nearest search reports the last probe on a miss
            if (!r.hit && op == OP_SEARCH && mid >= 0) r.position = tab_pos[mid];
         end
         OP_NEXT: r = cursor_read();
         OP_PREV: begin
            if (cur >= 2) begin
               cur -= 2;
               r = cursor_read();
            end else begin
               r = MISS_RES;
            end
         end
         OP_TOP: begin
            cur = 0;
            r = cursor_read();
         end
         OP_BOTTOM: begin
            if (tab_count > 0) begin
               cur = tab_count - 1;
               r = cursor_read();
            end else begin
               r = MISS_RES;
            end
         end
         default: begin
            tab_count = 0;
            cur = 0;
         end
      endcase
      return r;
   endfunction

   // Called on a falling edge; returns on the falling edge after the transfer.
   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [POS_W-1:0] rpos, input logic typed,
                           input res_type want);
      res_type r;
      if ($urandom_range(99) < tx_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {rpos, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = predict_result(op, key, rpos);
      pending.push_back(typed ? want : r);
      @(negedge clock);
   endtask

   task automatic issue(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                        input logic [POS_W-1:0] rpos);
      send_cmd(op, key, rpos, 1'b0, ZERO_RES);
   endtask

   // Hold the request side until every outstanding result has drained.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_key_bytes(input logic [KB_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cmp_bytes = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Ascending keys; duplicates appear once the key space runs out.
   task automatic load_sorted(input int n);
      logic [KEY_W-1:0] k, step;
      int               i;
      k = {$urandom, $urandom} >> $urandom_range(0, 63);
      for (i = 0; i < n; i++) begin
         issue(OP_LOAD, k, $urandom);
         step = ({$urandom, $urandom} >> $urandom_range(8, 63)) + 64'd1;
         if (k <= ~step) k = k + step;
      end
   endtask

   function automatic logic [KEY_W-1:0] stored_key();
      logic [KEY_W-1:0] k;
      k = tab_key[$urandom_range(tab_count - 1)];
      return k ^ ({$urandom, $urandom} & ~prefix_mask(cmp_bytes));
   endfunction

   task automatic run_phase(input logic [KB_W-1:0] kb, input int unsigned tx_pct,
                            input int unsigned rx_pct);
      int               i, r, pause_at;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] k;
      drain_results();
      write_key_bytes(kb);
      tx_gap_pct  = tx_pct;
      rx_idle_pct = rx_pct;
      issue(OP_CLEAR, {$urandom, $urandom}, $urandom);
      load_sorted(($urandom_range(9) == 0) ? $urandom_range(100, 200)
                                            : $urandom_range(1, 24));
      pause_at = $urandom_range(10, 70);
      for (i = 0; i < 80; i++) begin
         if (i == pause_at) drain_results();
         r = $urandom_range(99);
         if (r < 30 && tab_count > 0) begin
            issue(OP_FIND, stored_key(), $urandom);
         end else if (r < 45) begin
            op = $urandom_range(1) ? OP_FIND : OP_SEARCH;
            k = {$urandom, $urandom};
            if (tab_count > 0 && $urandom_range(1)) k = tab_key[$urandom_range(tab_count - 1)] + 1;
            issue(op, k, $urandom);
         end else if (r < 55 && tab_count > 0) begin
            issue(OP_SEARCH, stored_key(), $urandom);
         end else if (r < 85) begin
            case ($urandom_range(3))
               0: op = OP_NEXT;
               1: op = OP_PREV;
               2: op = OP_TOP;
               default: op = OP_BOTTOM;
            endcase
            issue(op, {$urandom, $urandom}, $urandom);
         end else if (r < 90) begin
            issue(OP_LOAD, {$urandom, $urandom}, $urandom);
         end else if (r < 93) begin
            issue(OP_CLEAR, {$urandom, $urandom}, $urandom);
            load_sorted($urandom_range(1, 8));
         end else begin
            issue(OP_W'($urandom_range(7)), {$urandom, $urandom}, $urandom);
         end
      end
   endtask

   function automatic void add_row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                   input logic [POS_W-1:0] rpos, input logic typed,
                                   input res_type want);
      stim_row_type row;
      row.typed = typed;
      row.op    = op;
      row.key   = key;
      row.rpos  = rpos;
      row.want  = want;
      plan.push_back(row);
   endfunction

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   always @(posedge clock) begin : rsp_check
      res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            $display("%0t unexpected result: expected none, got hit %b position %h overflow %b",
                     $time, rsp_tuser[0], rsp_tdata, rsp_tuser[1]);
            mismatch_count++;
         end else begin
            want = pending.pop_front();
            if (rsp_tuser[0] !== want.hit) begin
               $display("%0t hit mismatch: expected %b, got %b", $time, want.hit, rsp_tuser[0]);
               mismatch_count++;
            end
            if (rsp_tdata !== want.position) begin
               $display("%0t position mismatch: expected %h, got %h",
                        $time, want.position, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser[1] !== want.overflow) begin
               $display("%0t overflow mismatch: expected %b, got %b",
                        $time, want.overflow, rsp_tuser[1]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #6000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int i;
      // empty table: every lookup and cursor move misses
      add_row(OP_FIND,   64'h0, 32'h0, 1'b1, MISS_RES);
      add_row(OP_SEARCH, {KEY_W{1'b1}}, {POS_W{1'b1}}, 1'b1, MISS_RES);
      add_row(OP_NEXT,   64'h0, 32'h0, 1'b1, MISS_RES);
      add_row(OP_PREV,   64'h0, 32'h0, 1'b1, MISS_RES);
      add_row(OP_TOP,    64'h0, 32'h0, 1'b1, MISS_RES);
      add_row(OP_BOTTOM, 64'h0, 32'h0, 1'b1, MISS_RES);
      add_row(OP_LOAD,   64'h0, 32'h0, 1'b1, ZERO_RES);
      add_row(OP_LOAD,   64'h1, 32'h1, 1'b1, ZERO_RES);
      add_row(OP_LOAD,   64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1, ZERO_RES);
      add_row(OP_LOAD,   {KEY_W{1'b1}}, {POS_W{1'b1}}, 1'b1, ZERO_RES);
      add_row(OP_FIND,   {KEY_W{1'b1}}, 32'h0, 1'b0, ZERO_RES);
      add_row(OP_FIND,   64'h0, 32'h0, 1'b0, ZERO_RES);
      add_row(OP_FIND,   64'h4000_0000_0000_0000, 32'h0, 1'b0, ZERO_RES);
      add_row(OP_SEARCH, 64'h4000_0000_0000_0000, 32'h0, 1'b0, ZERO_RES);
      add_row(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFE, 32'h0, 1'b0, ZERO_RES);
      add_row(OP_TOP,    64'h0, 32'h0, 1'b0, ZERO_RES);
      add_row(OP_NEXT,   64'h0, 32'h0, 1'b0, ZERO_RES);
      add_row(OP_NEXT,   64'h0, 32'h0, 1'b0, ZERO_RES);
      add_row(OP_PREV,   64'h0, 32'h0, 1'b0, ZERO_RES);
      add_row(OP_BOTTOM, 64'h0, 32'h0, 1'b0, ZERO_RES);
      // cursor now past the last record
      add_row(OP_NEXT,   64'h0, 32'h0, 1'b1, MISS_RES);
      add_row(OP_PREV,   64'h0, 32'h0, 1'b0, ZERO_RES);
      add_row(OP_CLEAR,  {KEY_W{1'b1}}, {POS_W{1'b1}}, 1'b1, ZERO_RES);
      add_row(OP_NEXT,   64'h0, 32'h0, 1'b1, MISS_RES);
      add_row(OP_BOTTOM, 64'h0, 32'h0, 1'b1, MISS_RES);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < plan.size(); i++)
         send_cmd(plan[i].op, plan[i].key, plan[i].rpos, plan[i].typed, plan[i].want);

      run_phase(4'd8,  6,  60);
      run_phase(4'd1,  6,  60);
      run_phase(4'd0,  60, 6);
      run_phase(4'd15, 60, 6);
      run_phase(4'd3,  0,  0);
      run_phase(4'd8,  0,  0);

      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: files.f
src/skic_pkg.sv
src/skic_ram.sv
src/skic_engine.sv
src/sorted_key_index_cursor.sv
sim/testbench.sv
